// File: src/lph_pkg.sv
// package for the linear probe hash table
// types, codes and fnv-1a constants shared by the controller, datapath and top; no dependencies
package lph_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4,
        ST_REMOVED  = 3'd5,
        ST_CLEARED  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SL_EMPTY = 2'd0,
        SL_LIVE  = 2'd1,
        SL_TOMB  = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_HASH,
        FSM_READ,
        FSM_CHECK,
        FSM_WIPE,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [2:0]  status;
        logic [6:0]  occupied_count;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic rd;
        logic advance;
        logic finish;
        logic wipe;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_done;
        logic walk_end;
        logic wipe_done;
        logic clear_op;
    } sts_t;

endpackage

// File: src/lph_ram.sv
// generic single port ram with registered read
// no dependencies
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/lph_ctrl.sv
// controller state machine for the hash table
// depends on lph_pkg
module lph_ctrl
    import lph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    fsm_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            FSM_INIT:
            begin
                cmd.wipe = 1'b1;
                if (sts.wipe_done)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = FSM_HASH;
                end
            end
            FSM_HASH:
            begin
                if (sts.clear_op)
                begin
                    state_next = FSM_WIPE;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                    if (sts.hash_done)
                    begin
                        cmd.rd     = 1'b1;
                        state_next = FSM_READ;
                    end
                end
            end
            FSM_READ:
            begin
                state_next = FSM_CHECK;
            end
            FSM_CHECK:
            begin
                if (sts.walk_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = FSM_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.rd      = 1'b1;
                    state_next  = FSM_READ;
                end
            end
            FSM_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (sts.wipe_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// File: src/lph_dp.sv
// datapath: fnv-1a hash, probe walk, slot stores and counters
// depends on lph_pkg and lph_ram
module lph_dp
    import lph_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ordered_mode,
    input  in_word_t  in_word,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_word_t out_word
);

    localparam int AW     = $clog2(SLOTS);
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int NBYTES = (KEY_BITS + 7) / 8;
    localparam int BW     = $clog2(NBYTES + 1);

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [63:0]           hash_reg;
    logic [BW-1:0]         byte_reg;
    logic [AW-1:0]         idx_reg;
    logic [CW-1:0]         steps_reg;
    logic                  tomb_seen_reg;
    logic [AW-1:0]         tomb_idx_reg;
    logic [CW-1:0]         entry_reg;
    logic [CW-1:0]         entry_next;
    logic [AW-1:0]         wipe_reg;
    out_word_t             out_reg;
    out_word_t             out_next;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [1:0]            rd_st;
    logic [AW-1:0]         ram_addr;
    logic [AW-1:0]         st_addr;
    logic                  ram_we;
    logic                  st_we;
    logic [1:0]            st_wdata;
    logic [AW-1:0]         wr_addr;

    // one byte of fnv-1a per cycle, prime product as shifts and adds
    logic [7:0]  hbyte;
    logic [63:0] hmix;
    logic [63:0] hprod;
    logic [63:0] key64;
    logic [2:0]  bsel;
    assign key64 = 64'(key_reg);
    assign bsel  = 3'(byte_reg);
    assign hbyte = key64[8*bsel +: 8];
    assign hmix  = hash_reg ^ {56'd0, hbyte};
    assign hprod = (hmix << 40) + (hmix << 8) + (hmix << 7) + (hmix << 5)
                 + (hmix << 4) + (hmix << 1) + hmix;

    assign sts.hash_done = (byte_reg == BW'(NBYTES));
    assign sts.clear_op  = (op_reg == OP_CLEAR);
    assign sts.wipe_done = (wipe_reg == AW'(SLOTS - 1));

    logic [AW-1:0] home_idx;
    assign home_idx = AW'(hash_reg % 64'(SLOTS));

    logic [1:0] cur_st;
    logic       key_eq;
    logic       last_step;
    assign cur_st    = rd_st;
    assign key_eq    = (cur_st == SL_LIVE) && (rd_key == key_reg);
    assign last_step = (steps_reg == CW'(SLOTS - 1));
    assign sts.walk_end = (op_reg == OP_CLEAR) || (cur_st == SL_EMPTY) || key_eq || last_step;

    logic [AW-1:0] idx_inc;
    assign idx_inc = (idx_reg == AW'(SLOTS - 1)) ? '0 : idx_reg + AW'(1);

    logic [AW-1:0] wipe_inc;
    assign wipe_inc = (wipe_reg == AW'(SLOTS - 1)) ? '0 : wipe_reg + AW'(1);

    // resolve outcome of the walk
    logic          ins_ok;
    logic [AW-1:0] ins_idx;
    logic          tomb_now;
    assign tomb_now = (cur_st == SL_TOMB) && !tomb_seen_reg;
    always_comb
    begin
        ins_ok  = 1'b0;
        ins_idx = idx_reg;
        if (!ordered_mode && (tomb_seen_reg || tomb_now))
        begin
            ins_ok  = 1'b1;
            ins_idx = tomb_seen_reg ? tomb_idx_reg : idx_reg;
        end
        else if (cur_st == SL_EMPTY)
        begin
            ins_ok  = 1'b1;
            ins_idx = idx_reg;
        end
    end

    logic do_put_wr;
    assign do_put_wr = cmd.finish && (op_reg == OP_PUT) && (key_eq || ins_ok);
    assign ram_we    = do_put_wr;
    assign wr_addr   = key_eq ? idx_reg : ins_idx;
    assign ram_addr  = cmd.finish ? wr_addr :
                       (cmd.advance ? idx_inc : (cmd.rd ? home_idx : idx_reg));

    // slot state store, cleared by a pass over all slots
    assign st_addr  = cmd.wipe ? wipe_reg : ram_addr;
    assign st_we    = cmd.wipe
                   || (cmd.finish && (op_reg == OP_PUT) && !key_eq && ins_ok)
                   || (cmd.finish && (op_reg == OP_REMOVE) && key_eq);
    assign st_wdata = cmd.wipe ? SL_EMPTY : ((op_reg == OP_PUT) ? SL_LIVE : SL_TOMB);

    lph_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
        .clk   (clk),
        .we    (ram_we && !key_eq),
        .addr  (ram_addr),
        .wdata (key_reg),
        .rdata (rd_key)
    );

    lph_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (val_reg),
        .rdata (rd_val)
    );

    lph_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_st_ram (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (st_wdata),
        .rdata (rd_st)
    );

    always_comb
    begin
        out_next   = '0;
        entry_next = entry_reg;
        case (op_reg)
            OP_CLEAR:
            begin
                entry_next      = '0;
                out_next.status = ST_CLEARED;
            end
            OP_PUT:
            begin
                if (key_eq)
                begin
                    out_next.found  = 1'b1;
                    out_next.status = ST_UPDATED;
                end
                else if (ins_ok)
                begin
                    entry_next      = entry_reg + CW'(1);
                    out_next.status = ST_INSERTED;
                end
                else
                begin
                    out_next.status = ST_FULL;
                end
            end
            default:
            begin
                if (key_eq)
                begin
                    out_next.found     = 1'b1;
                    out_next.value_out = 32'(rd_val);
                    if (op_reg == OP_GET)
                    begin
                        out_next.status = ST_HIT;
                    end
                    else
                    begin
                        entry_next      = entry_reg - CW'(1);
                        out_next.status = ST_REMOVED;
                    end
                end
                else
                begin
                    out_next.status = ST_MISS;
                end
            end
        endcase
        out_next.occupied_count = 7'(entry_next);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_word.operation;
            key_reg  <= in_word.key[KEY_BITS-1:0];
            val_reg  <= VALUE_BITS'(in_word.value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_OFFSET;
            byte_reg      <= '0;
            idx_reg       <= '0;
            steps_reg     <= '0;
            tomb_seen_reg <= 1'b0;
            tomb_idx_reg  <= '0;
            entry_reg     <= '0;
            wipe_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                hash_reg      <= FNV_OFFSET;
                byte_reg      <= '0;
                tomb_seen_reg <= 1'b0;
                steps_reg     <= '0;
            end
            if (cmd.hash_step && !sts.hash_done)
            begin
                hash_reg <= hprod;
                byte_reg <= byte_reg + BW'(1);
            end
            if (cmd.hash_step && sts.hash_done)
            begin
                idx_reg <= home_idx;
            end
            if (cmd.advance)
            begin
                idx_reg   <= idx_inc;
                steps_reg <= steps_reg + CW'(1);
                if (tomb_now)
                begin
                    tomb_seen_reg <= 1'b1;
                    tomb_idx_reg  <= idx_reg;
                end
            end
            if (cmd.wipe)
            begin
                wipe_reg <= wipe_inc;
            end
            if (cmd.finish)
            begin
                out_reg   <= out_next;
                entry_reg <= entry_next;
            end
        end
    end

    assign out_word = out_reg;

endmodule

// File: src/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing. One word is taken at a time:
// the FNV-1a hash is computed one key byte at a time with shifts and adds, then the
// probe walk reads one slot at a time from the slot memories through the READ and
// CHECK states. The next word can be taken from the cycle after the result is
// taken. Slot states live in a memory that is cleared one slot per cycle: after
// reset in_ready stays low until every slot is cleared, and a clear presents its
// result once every slot has been cleared. ordered_mode is written through cfg_we /
// cfg_data; the user must write it only while idle, the block does not enforce it.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic ordered_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            ordered_reg <= cfg_data;
        end
    end

    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lph_dp #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ordered_mode (ordered_reg),
        .in_word      (in_data),
        .cmd          (cmd),
        .sts          (sts),
        .out_word     (out_data)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.occupied_count <= 7'(SLOTS)))
        else $error("count out of range");
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_CLEARED) |-> (out_data.occupied_count == 7'd0))
        else $error("clear left entries");
`endif

endmodule
